[rtl/ifbs_pkg.sv]
// Shared types and constants for the info frame byte stuffer.
`timescale 1ns / 1ps
package ifbs_pkg;

  localparam int unsigned SEQ_SHIFT = 6;

  // Configuration register indexes
  localparam logic [1:0] REG_FLAG    = 2'd0;
  localparam logic [1:0] REG_ESCAPE  = 2'd1;
  localparam logic [1:0] REG_MASK    = 2'd2;
  localparam logic [1:0] REG_ADDRESS = 2'd3;

  // Reset values of the configuration registers
  localparam logic [7:0] FLAG_RST    = 8'd126;
  localparam logic [7:0] ESCAPE_RST  = 8'd125;
  localparam logic [7:0] MASK_RST    = 8'd32;
  localparam logic [7:0] ADDRESS_RST = 8'd3;

  typedef struct packed {
    logic [7:0] flag;
    logic [7:0] escape;
    logic [7:0] mask;
    logic [7:0] address;
  } cfg_t;

  // One classified payload byte, as handed from the front to the back end
  typedef struct packed {
    logic       hdr;        // first byte of a frame: header goes out first
    logic       last;       // close the frame after this byte
    logic [7:0] ctrl;       // control byte of the header
    logic [7:0] data;       // raw payload byte
    logic [7:0] check;      // check byte, valid when last
    logic       data_esc;   // payload byte needs an escape pair
    logic       check_esc;  // check byte needs an escape pair
  } job_t;

endpackage

[rtl/ifbs_in_if.sv]
// Input channel: payload bytes with valid/ready handshake.
`timescale 1ns / 1ps
interface ifbs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic       sequence_bit;
  logic       last_payload;

  modport source (output valid, output payload_byte, output sequence_bit,
                  output last_payload, input ready);
  modport sink (input valid, input payload_byte, input sequence_bit,
                input last_payload, output ready);
endinterface

[rtl/ifbs_out_if.sv]
// Output channel: framed, stuffed bytes with valid/ready handshake.
`timescale 1ns / 1ps
interface ifbs_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       end_of_run;
  logic       end_of_frame;

  modport source (output valid, output out_byte, output end_of_run,
                  output end_of_frame, input ready);
  modport sink (input valid, input out_byte, input end_of_run,
                input end_of_frame, output ready);
endinterface

[rtl/ifbs_front.sv]
// Front end: accepts payload bytes, tracks frame state and running check.
`timescale 1ns / 1ps
module ifbs_front (
  input  logic          clk,
  input  logic          rst,
  ifbs_in_if.sink       in_stream,
  input  ifbs_pkg::cfg_t cfg,
  input  logic          queue_full,
  output logic          push,
  output ifbs_pkg::job_t job
);

  logic       frame_open;
  logic [7:0] running_check;
  logic [7:0] check_next;

  assign in_stream.ready = !queue_full;
  assign push            = in_stream.valid && !queue_full;

  // new frame restarts the check from this byte
  assign check_next = frame_open ? (running_check ^ in_stream.payload_byte)
                                 : in_stream.payload_byte;

  always_comb begin
    job.hdr       = !frame_open;
    job.last      = in_stream.last_payload;
    job.ctrl      = 8'(in_stream.sequence_bit) << ifbs_pkg::SEQ_SHIFT;
    job.data      = in_stream.payload_byte;
    job.check     = check_next;
    job.data_esc  = (in_stream.payload_byte == cfg.flag) ||
                    (in_stream.payload_byte == cfg.escape);
    job.check_esc = (check_next == cfg.flag) || (check_next == cfg.escape);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_open    <= 1'b0;
      running_check <= 8'd0;
    end else if (push) begin
      frame_open    <= !in_stream.last_payload;
      running_check <= in_stream.last_payload ? 8'd0 : check_next;
    end
  end

endmodule

[rtl/ifbs_queue.sv]
// Small FIFO of classified jobs between front and back end.
`timescale 1ns / 1ps
module ifbs_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  ifbs_pkg::job_t push_job,
  input  logic           pop,
  output ifbs_pkg::job_t head,
  output logic           empty,
  output logic           full
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  ifbs_pkg::job_t    mem [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              do_push;
  logic              do_pop;

  assign empty   = (count == '0);
  assign full    = (count == CNT_W'(DEPTH));
  assign head    = mem[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

[rtl/ifbs_back.sv]
// Back end: walks each job byte by byte into a registered output stage.
`timescale 1ns / 1ps
module ifbs_back (
  input  logic           clk,
  input  logic           rst,
  input  ifbs_pkg::cfg_t cfg,
  input  ifbs_pkg::job_t head,
  input  logic           empty,
  output logic           pop,
  ifbs_out_if.source     out_stream
);

  typedef enum logic [3:0] {
    S_START, S_FLAG, S_ADDR, S_CTRL, S_BCC,
    S_DATA, S_DATA2, S_CHK, S_CHK2, S_CLOSE
  } step_t;

  step_t      step;
  step_t      cur;
  step_t      step_next;
  logic       advance;
  logic       done;
  logic       eof;
  logic [7:0] byte_out;
  logic       out_valid;
  logic [7:0] out_byte;
  logic       out_eor;
  logic       out_eof;

  assign out_stream.valid        = out_valid;
  assign out_stream.out_byte     = out_byte;
  assign out_stream.end_of_run   = out_eor;
  assign out_stream.end_of_frame = out_eof;

  // one byte per cycle while the queue holds a job and the output stage is free or draining
  assign advance = !empty && (!out_valid || out_stream.ready);
  assign pop     = advance && done;

  always_comb begin
    cur       = (step == S_START) ? (head.hdr ? S_FLAG : S_DATA) : step;
    byte_out  = head.data;
    step_next = S_START;
    done      = 1'b0;
    eof       = 1'b0;
    case (cur)
      S_FLAG: begin
        byte_out  = cfg.flag;
        step_next = S_ADDR;
      end
      S_ADDR: begin
        byte_out  = cfg.address;
        step_next = S_CTRL;
      end
      S_CTRL: begin
        byte_out  = head.ctrl;
        step_next = S_BCC;
      end
      S_BCC: begin
        byte_out  = cfg.address ^ head.ctrl;
        step_next = S_DATA;
      end
      S_DATA: begin
        if (head.data_esc) begin
          byte_out  = cfg.escape;
          step_next = S_DATA2;
        end else begin
          byte_out  = head.data;
          step_next = head.last ? S_CHK : S_START;
          done      = !head.last;
        end
      end
      S_DATA2: begin
        byte_out  = head.data ^ cfg.mask;
        step_next = head.last ? S_CHK : S_START;
        done      = !head.last;
      end
      S_CHK: begin
        if (head.check_esc) begin
          byte_out  = cfg.escape;
          step_next = S_CHK2;
        end else begin
          byte_out  = head.check;
          step_next = S_CLOSE;
        end
      end
      S_CHK2: begin
        byte_out  = head.check ^ cfg.mask;
        step_next = S_CLOSE;
      end
      S_CLOSE: begin
        byte_out  = cfg.flag;
        step_next = S_START;
        done      = 1'b1;
        eof       = 1'b1;
      end
      default: begin
        byte_out  = head.data;
        step_next = S_START;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= S_START;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        step      <= step_next;
        out_valid <= 1'b1;
        out_byte  <= byte_out;
        out_eor   <= done;
        out_eof   <= eof;
      end else if (out_stream.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

[rtl/info_frame_byte_stuffer.sv]
// Top level of the info frame byte stuffer: config registers and datapath.
`timescale 1ns / 1ps
// Builds HDLC-like information frames from a stream of payload bytes.
// in_stream carries payload_byte, sequence_bit and last_payload; a transaction
// takes place on a rising edge with valid and ready both high. out_stream
// carries out_byte, end_of_run and end_of_frame under the same handshake.
// The first byte of a packet brings a four-byte header (flag, address,
// control, header check); each payload byte goes out stuffed (one or two
// bytes); the last byte adds the stuffed check byte and a closing flag.
// One input transaction thus yields 1 to 9 output bytes.
// The front end takes one input per cycle into a job queue (QUEUE_DEPTH
// entries) while the queue has room. The back end emits one output byte
// per cycle from the queue head into an output register while the queue
// holds a job and the output register is free or draining, so throughput is
// set by the output byte count. An input byte passes through a queue entry
// and then the output register before it appears on out_stream.
// When the receiver stalls, the output register holds its byte, the back end
// stops, the queue fills and in_stream.ready drops.
// Synchronous reset empties the queue and output stage, closes any open frame
// and restores the configuration registers. Config writes (cfg_we, cfg_index,
// cfg_data) take effect the next cycle and are meant for an idle block.
module info_frame_byte_stuffer #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  ifbs_in_if.sink     in_stream,
  ifbs_out_if.source  out_stream,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  ifbs_pkg::cfg_t cfg;
  ifbs_pkg::job_t front_job;
  ifbs_pkg::job_t head_job;
  logic           push;
  logic           pop;
  logic           q_empty;
  logic           q_full;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.flag    <= ifbs_pkg::FLAG_RST;
      cfg.escape  <= ifbs_pkg::ESCAPE_RST;
      cfg.mask    <= ifbs_pkg::MASK_RST;
      cfg.address <= ifbs_pkg::ADDRESS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        ifbs_pkg::REG_FLAG:    cfg.flag    <= cfg_data;
        ifbs_pkg::REG_ESCAPE:  cfg.escape  <= cfg_data;
        ifbs_pkg::REG_MASK:    cfg.mask    <= cfg_data;
        ifbs_pkg::REG_ADDRESS: cfg.address <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // frame tracking and stuff classification
  ifbs_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_stream  (in_stream),
    .cfg        (cfg),
    .queue_full (q_full),
    .push       (push),
    .job        (front_job)
  );

  ifbs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (front_job),
    .pop      (pop),
    .head     (head_job),
    .empty    (q_empty),
    .full     (q_full)
  );

  // byte sequencer and output register
  ifbs_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head       (head_job),
    .empty      (q_empty),
    .pop        (pop),
    .out_stream (out_stream)
  );

endmodule

[rtl/ifbs_checker.sv]
// Port-level assertions for the info frame byte stuffer, bound to the top.
`timescale 1ns / 1ps
module ifbs_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       out_eor,
  input logic       out_eof
);

  // nothing comes out in the cycle after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid right after reset");

  // the queue is empty after reset, so input is taken at once
  a_reset_ready: assert property (@(posedge clk) rst |=> in_ready)
    else $error("input not ready after reset");

  // a closing flag always ends the run of its input transaction
  a_eof_ends_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_eof |-> out_eor)
    else $error("closing flag without end of run");

  // stalled output transaction holds its byte
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) &&
      $stable(out_eor) && $stable(out_eof))
    else $error("output changed while stalled");

endmodule

bind info_frame_byte_stuffer ifbs_checker u_ifbs_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_stream.ready),
  .out_valid (out_stream.valid),
  .out_ready (out_stream.ready),
  .out_byte  (out_stream.out_byte),
  .out_eor   (out_stream.end_of_run),
  .out_eof   (out_stream.end_of_frame)
);

[tb/sv/testbench.sv]
// Self-checking testbench for the info frame byte stuffer.
`timescale 1ns / 1ps
module testbench;

  // One payload transaction waiting to be offered, with the idle cycles
  // the sender inserts ahead of it.
  typedef struct {
    logic [7:0] payload;
    logic       seq;
    logic       last;
    int         gap;
  } payload_item_t;

  // One output byte as seen on out_stream.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       end_of_run;
    logic       end_of_frame;
  } frame_byte_t;

  localparam int HOLD_AT     = 120;  // accepted inputs before the long stall
  localparam int HOLD_CYCLES = 400;  // length of the long receiver stall

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_we;
  logic [1:0] cfg_index;
  logic [7:0] cfg_data;

  ifbs_in_if  in_ch ();
  ifbs_out_if out_ch ();

  info_frame_byte_stuffer dut (
    .clk        (clk),
    .rst        (rst),
    .in_stream  (in_ch),
    .out_stream (out_ch),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #6 clk = ~clk;

  // Testbench copy of the configuration and of the framing state.
  ifbs_pkg::cfg_t link_cfg;
  logic [7:0]     payload_xor;
  logic           frame_in_progress;

  payload_item_t payload_backlog[$];
  frame_byte_t   frame_bytes_due[$];

  // Stimulus shaping, set per phase by the sequencer.
  logic tx_quiet;
  logic rx_quiet;

  // Bookkeeping.
  int items_in;
  int tx_wait;
  int rx_wait;
  int rx_next;
  int hold_left;
  logic hold_done;
  int fail_count;
  int bytes_checked;
  int frames_seen;
  int escapes_due;
  int cfg_writes;
  int pkt_left;
  frame_byte_t seen_byte;

  //--------------------------------------------------------------------------
  // Prediction: expected output bytes for one accepted payload transaction.
  //--------------------------------------------------------------------------
  function automatic void put_byte(logic [7:0] b, logic eof);
    frame_byte_t r;
    r.out_byte     = b;
    r.end_of_run   = 1'b0;
    r.end_of_frame = eof;
    frame_bytes_due.push_back(r);
  endfunction

  // Flag or escape values go out as an escape pair; anything else as is.
  function automatic void put_stuffed(logic [7:0] b);
    if (b == link_cfg.flag || b == link_cfg.escape) begin
      put_byte(link_cfg.escape, 1'b0);
      put_byte(b ^ link_cfg.mask, 1'b0);
      escapes_due++;
    end else begin
      put_byte(b, 1'b0);
    end
  endfunction

  function automatic void frame_encode(logic [7:0] data, logic seq, logic last);
    logic [7:0]  ctrl;
    frame_byte_t tail;
    // First byte of a packet: unstuffed header ahead of the payload.
    // The sequence bit of any later byte is ignored.
    if (!frame_in_progress) begin
      ctrl = 8'(seq) << ifbs_pkg::SEQ_SHIFT;
      put_byte(link_cfg.flag, 1'b0);
      put_byte(link_cfg.address, 1'b0);
      put_byte(ctrl, 1'b0);
      put_byte(link_cfg.address ^ ctrl, 1'b0);
      payload_xor       = 8'h00;
      frame_in_progress = 1'b1;
    end
    put_stuffed(data);
    payload_xor = payload_xor ^ data;
    // Last byte: stuffed check byte, then the closing flag.
    if (last) begin
      put_stuffed(payload_xor);
      put_byte(link_cfg.flag, 1'b1);
      payload_xor       = 8'h00;
      frame_in_progress = 1'b0;
    end
    // The final byte this transaction causes carries end_of_run.
    tail = frame_bytes_due.pop_back();
    tail.end_of_run = 1'b1;
    frame_bytes_due.push_back(tail);
  endfunction

  //--------------------------------------------------------------------------
  // Checking: each output transaction against the oldest expectation.
  //--------------------------------------------------------------------------
  function automatic void check_frame_byte(frame_byte_t got);
    frame_byte_t want;
    if (got.end_of_frame === 1'b1) frames_seen++;
    if (frame_bytes_due.size() == 0) begin
      fail_count++;
      if (fail_count <= 10)
        $display("ERROR: unexpected output byte=%h eor=%b eof=%b at %0t",
                 got.out_byte, got.end_of_run, got.end_of_frame, $realtime);
    end else begin
      want = frame_bytes_due.pop_front();
      bytes_checked++;
      if (got.out_byte !== want.out_byte || got.end_of_run !== want.end_of_run ||
          got.end_of_frame !== want.end_of_frame) begin
        fail_count++;
        if (fail_count <= 10)
          $display("ERROR: byte %0d exp byte=%h eor=%b eof=%b got byte=%h eor=%b eof=%b",
                   bytes_checked, want.out_byte, want.end_of_run, want.end_of_frame,
                   got.out_byte, got.end_of_run, got.end_of_frame);
      end
    end
  endfunction

  // No wait when quiet; else mostly none, now and then a random idle wait.
  function automatic int draw_wait(logic quiet);
    int w;
    w = 0;
    if (!quiet && $urandom_range(0, 2) == 0) w = $urandom_range(0, 18);
    return w;
  endfunction

  //--------------------------------------------------------------------------
  // Driver: offers backlog items on in_stream, each after its own gap.
  // A transaction completes on an edge with valid and ready both high;
  // the item is predicted right there, with the config of that moment.
  //--------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
      tx_wait     <= 0;
      items_in    <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        frame_encode(in_ch.payload_byte, in_ch.sequence_bit, in_ch.last_payload);
        items_in <= items_in + 1;
      end
      // Slot is free when nothing is offered or the offer was just taken.
      if (!in_ch.valid || in_ch.ready) begin
        if (payload_backlog.size() == 0) begin
          in_ch.valid <= 1'b0;
        end else if (tx_wait < payload_backlog[0].gap) begin
          in_ch.valid <= 1'b0;
          tx_wait     <= tx_wait + 1;
        end else begin
          in_ch.payload_byte <= payload_backlog[0].payload;
          in_ch.sequence_bit <= payload_backlog[0].seq;
          in_ch.last_payload <= payload_backlog[0].last;
          in_ch.valid        <= 1'b1;
          tx_wait            <= 0;
          void'(payload_backlog.pop_front());
        end
      end
    end
  end

  //--------------------------------------------------------------------------
  // Long receiver stall, once, counted here: the sender keeps offering,
  // so the job queue fills and in_stream.ready has to drop.
  //--------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && items_in >= HOLD_AT) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  //--------------------------------------------------------------------------
  // Monitor: takes output transactions and stalls a random count after each.
  //--------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
      rx_wait      <= 0;
    end else begin
      rx_next = rx_wait;
      if (out_ch.valid && out_ch.ready) begin
        seen_byte = {out_ch.out_byte, out_ch.end_of_run, out_ch.end_of_frame};
        check_frame_byte(seen_byte);
        rx_next = draw_wait(rx_quiet);
      end
      if (hold_left != 0) begin
        out_ch.ready <= 1'b0;
      end else if (rx_next != 0) begin
        out_ch.ready <= 1'b0;
        rx_next = rx_next - 1;
      end else begin
        out_ch.ready <= 1'b1;
      end
      rx_wait <= rx_next;
    end
  end

  //--------------------------------------------------------------------------
  // Stimulus helpers.
  //--------------------------------------------------------------------------
  function automatic void add_item(logic [7:0] payload, logic seq, logic last);
    payload_item_t it;
    it.payload = payload;
    it.seq     = seq;
    it.last    = last;
    it.gap     = draw_wait(tx_quiet);
    payload_backlog.push_back(it);
  endfunction

  // Bias payload toward the values that need stuffing.
  function automatic logic [7:0] pick_payload();
    logic [7:0] b;
    case ($urandom_range(0, 5))
      0:       b = link_cfg.flag;
      1:       b = link_cfg.escape;
      2:       b = link_cfg.flag ^ link_cfg.mask;
      default: b = 8'($urandom_range(0, 255));
    endcase
    return b;
  endfunction

  // Packets of random length; a phase may stop in the middle of a packet,
  // leaving the frame open across the next config change.
  task automatic queue_random_items(int count);
    int i;
    for (i = 0; i < count; i++) begin
      if (pkt_left == 0)
        pkt_left = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 30)
                                                : $urandom_range(1, 4);
      add_item(pick_payload(), 1'($urandom_range(0, 1)), pkt_left == 1);
      pkt_left--;
    end
  endtask

  task automatic write_reg(logic [1:0] idx, logic [7:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      ifbs_pkg::REG_FLAG:    link_cfg.flag    = val;
      ifbs_pkg::REG_ESCAPE:  link_cfg.escape  = val;
      ifbs_pkg::REG_MASK:    link_cfg.mask    = val;
      ifbs_pkg::REG_ADDRESS: link_cfg.address = val;
      default: ;
    endcase
    cfg_writes++;
  endtask

  task automatic write_config(logic [7:0] f, logic [7:0] e, logic [7:0] m,
                              logic [7:0] a);
    write_reg(ifbs_pkg::REG_FLAG, f);
    write_reg(ifbs_pkg::REG_ESCAPE, e);
    write_reg(ifbs_pkg::REG_MASK, m);
    write_reg(ifbs_pkg::REG_ADDRESS, a);
    @(negedge clk);
  endtask

  // Block is idle once nothing is offered and every byte has come out.
  task automatic wait_idle();
    while (payload_backlog.size() != 0 || in_ch.valid || frame_bytes_due.size() != 0)
      @(negedge clk);
  endtask

  //--------------------------------------------------------------------------
  // Sequencer.
  //--------------------------------------------------------------------------
  initial begin
    int p;
    logic [7:0] f;
    in_ch.valid        = 1'b0;
    in_ch.payload_byte = 8'h00;
    in_ch.sequence_bit = 1'b0;
    in_ch.last_payload = 1'b0;
    out_ch.ready       = 1'b0;
    cfg_we             = 1'b0;
    cfg_index          = ifbs_pkg::REG_FLAG;
    cfg_data           = 8'h00;
    link_cfg           = '{flag: ifbs_pkg::FLAG_RST, escape: ifbs_pkg::ESCAPE_RST,
                           mask: ifbs_pkg::MASK_RST, address: ifbs_pkg::ADDRESS_RST};
    payload_xor        = 8'h00;
    frame_in_progress  = 1'b0;
    tx_quiet           = 1'b0;
    rx_quiet           = 1'b0;
    fail_count         = 0;
    bytes_checked      = 0;
    frames_seen        = 0;
    escapes_due        = 0;
    cfg_writes         = 0;
    pkt_left           = 0;

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed, reset config: single- and multi-byte packets on flag/escape/extremes,
    // seq bit on later bytes ignored, check bytes that land on flag/escape.
    add_item(8'h7E, 1'b1, 1'b1);
    add_item(8'h7D, 1'b0, 1'b0);
    add_item(8'h00, 1'b1, 1'b0);
    add_item(8'hFF, 1'b0, 1'b0);
    add_item(8'h5D, 1'b1, 1'b1);
    add_item(8'h70, 1'b0, 1'b0);
    add_item(8'h0E, 1'b0, 1'b1);   // check = flag
    add_item(8'h7C, 1'b1, 1'b0);
    add_item(8'h01, 1'b0, 1'b1);   // check = escape
    add_item(8'h00, 1'b0, 1'b1);
    add_item(8'hFF, 1'b1, 1'b1);
    wait_idle();

    // Flag equal to escape, address equal to flag, full mask.
    write_config(8'h55, 8'h55, 8'hFF, 8'h55);
    add_item(8'h55, 1'b1, 1'b1);
    add_item(8'hAA, 1'b0, 1'b0);
    add_item(8'h55, 1'b1, 1'b1);
    add_item(8'h3C, 1'b0, 1'b0);   // frame left open
    wait_idle();

    // Config change while a frame is open; header check hits the escape.
    write_config(8'h00, 8'hFF, 8'h00, 8'hFF);
    add_item(8'h00, 1'b1, 1'b0);
    add_item(8'hFF, 1'b0, 1'b0);
    add_item(8'h80, 1'b1, 1'b1);
    add_item(8'h00, 1'b0, 1'b1);
    wait_idle();

    // Random phases: reset values, all zero, all ones, then random settings.
    for (p = 0; p < 5; p++) begin
      case (p)
        0: write_config(ifbs_pkg::FLAG_RST, ifbs_pkg::ESCAPE_RST, ifbs_pkg::MASK_RST,
                        ifbs_pkg::ADDRESS_RST);
        1: write_config(8'h00, 8'h00, 8'h00, 8'h00);
        2: write_config(8'hFF, 8'hFF, 8'hFF, 8'hFF);
        default: begin
          f = 8'($urandom_range(0, 255));
          write_config(f, ($urandom_range(0, 1) == 0) ? f : 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        end
      endcase
      tx_quiet = (p == 0 || p == 3);
      rx_quiet = (p == 0);
      queue_random_items(58);
      wait_idle();
    end

    // Drain, then wait for stray output.
    repeat (12) @(posedge clk);
    @(negedge clk);
    if (frame_bytes_due.size() != 0) begin
      fail_count++;
      $display("ERROR: %0d expected bytes never arrived", frame_bytes_due.size());
    end

    $display("Run covered %0d payload transactions, %0d output bytes, %0d closed frames,",
             items_in, bytes_checked, frames_seen);
    $display("%0d escape pairs and %0d register writes; %0d failures.",
             escapes_due, cfg_writes, fail_count);
    if (fail_count == 0) begin
      $display("info_frame_byte_stuffer: match");
    end else begin
      $display("info_frame_byte_stuffer: mismatch");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("ERROR: timeout, %0d bytes still expected", frame_bytes_due.size());
    $display("info_frame_byte_stuffer: mismatch");
    $finish;
  end

endmodule
